[sv/forth_data_stack_alu_macros.svh]
// Assertion macros used by the port checker file.
`ifndef FORTH_DATA_STACK_ALU_MACROS_SVH
`define FORTH_DATA_STACK_ALU_MACROS_SVH

// Implication checked at every rising clock edge, reset masked.
`define FDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fds_pkg.sv]
// Package with opcodes, error codes and command types of the Forth stack unit.
package fds_pkg;

    typedef enum logic [4:0] {
        OP_LIT = 5'd0, OP_DUP = 5'd1, OP_DROP = 5'd2, OP_SWAP = 5'd3, OP_NIP = 5'd4,
        OP_2DROP = 5'd5, OP_OVER = 5'd6, OP_ADD = 5'd7, OP_SUB = 5'd8, OP_MUL = 5'd9,
        OP_DIV = 5'd10, OP_AND = 5'd11, OP_OR = 5'd12, OP_XOR = 5'd13, OP_NEG = 5'd14,
        OP_INV = 5'd15, OP_2MUL = 5'd16, OP_2DIV = 5'd17, OP_U2DIV = 5'd18,
        OP_LSH = 5'd19, OP_ASR = 5'd20, OP_LSR = 5'd21, OP_ULT = 5'd22, OP_LT = 5'd23,
        OP_GT = 5'd24, OP_0LT = 5'd25, OP_0EQ = 5'd26, OP_UMOD = 5'd27,
        OP_FMOD = 5'd28, OP_NOP29 = 5'd29, OP_NOP30 = 5'd30, OP_NOP31 = 5'd31
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_UNFL = 2'd1, ERR_OVFL = 2'd2, ERR_DIVZ = 2'd3
    } t_err;

    // Cells consumed by each opcode.
    function automatic logic [1:0] pop_count(input t_op op);
        case (op)
            OP_LIT, OP_NOP29, OP_NOP30, OP_NOP31: pop_count = 2'd0;
            OP_DUP, OP_DROP, OP_NEG, OP_INV, OP_2MUL, OP_2DIV, OP_U2DIV,
            OP_0LT, OP_0EQ: pop_count = 2'd1;
            default: pop_count = 2'd2;
        endcase
    endfunction

    // Cells produced by each opcode.
    function automatic logic [1:0] push_count(input t_op op);
        case (op)
            OP_DROP, OP_2DROP, OP_NOP29, OP_NOP30, OP_NOP31: push_count = 2'd0;
            OP_DUP, OP_SWAP, OP_UMOD, OP_FMOD: push_count = 2'd2;
            OP_OVER: push_count = 2'd3;
            default: push_count = 2'd1;
        endcase
    endfunction

    function automatic logic is_div(input t_op op);
        is_div = (op == OP_DIV) || (op == OP_UMOD) || (op == OP_FMOD);
    endfunction

    // Controller to datapath commands.
    typedef struct packed {
        logic div_start; // start the divider
        logic div_step;  // one division step
        logic commit;    // write results, update depth
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

[sv/forth_data_stack_alu.sv]
// Top level of the Forth data-stack execution unit.
//  channel | dir | tdata fields                                    | tuser
//  s_axis  | in  | mode[4:0], literal[36:5]                        | none
//  m_axis  | out | top_value, second_value, stack_depth, error      | none
// Stack words other than division: the result is valid in the cycle after the word is taken.
// /, u/mod and /mod run the one-bit-per-cycle divider.
// Reset clears the depth and the top registers; the stack memory is not cleared.
// A result waiting on m_axis holds off the next word on s_axis.
module forth_data_stack_alu import fds_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int CELL_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // mode[4:0], literal[36:5], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // top[31:0], second[63:32], depth[69:64], error[71:70]
);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    t_cmd w_cmd;
    t_sts w_sts;
    t_op  r_op, w_op;
    logic [31:0] r_lit;
    logic [CELL_BITS-1:0] w_top, w_sec;
    logic [DW-1:0] w_depth;
    logic [1:0] w_err;
    logic w_bzero, w_hold;
    logic [63:0] w_top64, w_sec64;

    // Opcode is held during division.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= t_op'(s_axis_tdata[4:0]);
            r_lit <= s_axis_tdata[36:5];
        end
    end
    assign w_op = w_hold ? r_op : t_op'(s_axis_tdata[4:0]);

    fds_control #(.STACK_DEPTH(STACK_DEPTH)) u_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(w_op), .i_depth(w_depth), .i_bzero(w_bzero), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_err(w_err),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .o_hold(w_hold)
    );

    fds_datapath #(.STACK_DEPTH(STACK_DEPTH), .CELL_BITS(CELL_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_op(w_op),
        .i_literal(w_hold ? r_lit : s_axis_tdata[36:5]),
        .o_sts(w_sts), .o_top(w_top), .o_second(w_sec), .o_depth(w_depth),
        .o_bzero(w_bzero)
    );

    // Output word taken from the live top registers.
    assign w_top64 = 64'(w_top);
    assign w_sec64 = 64'(w_sec);
    assign m_axis_tdata = {w_err, 6'(w_depth), w_sec64[31:0], w_top64[31:0]};
endmodule

[sv/fds_divider.sv]
// Restoring divider, one quotient bit per cycle while i_step is high, with sign fix-up.
module fds_divider import fds_pkg::*; #(
    parameter int CELL_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_step,
    input  logic                 i_signed,
    input  logic                 i_floor,
    input  logic [CELL_BITS-1:0] i_a,
    input  logic [CELL_BITS-1:0] i_b,
    output logic                 o_done,
    output logic [CELL_BITS-1:0] o_quot,
    output logic [CELL_BITS-1:0] o_rem
);
    localparam int CW = $clog2(CELL_BITS + 1);

    logic [CELL_BITS-1:0] r_q, r_d, r_r;
    logic [CW-1:0]        r_cnt;
    logic                 r_qneg, r_rneg, r_floor;
    logic [CELL_BITS-1:0] r_borig;
    logic [CELL_BITS:0]   w_trial;
    logic [CELL_BITS-1:0] w_ma, w_mb, w_q, w_r, w_qf, w_rf;

    assign w_ma = (i_signed && i_a[CELL_BITS-1]) ? (~i_a + 1'b1) : i_a;
    assign w_mb = (i_signed && i_b[CELL_BITS-1]) ? (~i_b + 1'b1) : i_b;
    assign w_trial = {r_r, r_q[CELL_BITS-1]} - {1'b0, r_d};

    // Operands in magnitude form, then one shift-subtract per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_q     <= w_ma;
            r_d     <= w_mb;
            r_r     <= '0;
            r_cnt   <= CW'(CELL_BITS);
            r_qneg  <= i_signed && (i_a[CELL_BITS-1] ^ i_b[CELL_BITS-1]);
            r_rneg  <= i_signed && i_a[CELL_BITS-1];
            r_floor <= i_floor;
            r_borig <= i_b;
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (!w_trial[CELL_BITS]) begin
                r_r <= w_trial[CELL_BITS-1:0];
                r_q <= {r_q[CELL_BITS-2:0], 1'b1};
            end else begin
                r_r <= {r_r[CELL_BITS-2:0], r_q[CELL_BITS-1]};
                r_q <= {r_q[CELL_BITS-2:0], 1'b0};
            end
        end
    end

    // Truncating signs, then the floored correction.
    assign w_q  = r_qneg ? (~r_q + 1'b1) : r_q;
    assign w_r  = r_rneg ? (~r_r + 1'b1) : r_r;
    assign w_qf = w_q - 1'b1;
    assign w_rf = w_r + r_borig;
    assign o_done = (r_cnt == '0);
    assign o_quot = (r_floor && r_qneg && r_r != '0) ? w_qf : w_q;
    assign o_rem  = (r_floor && r_qneg && r_r != '0) ? w_rf : w_r;
endmodule

[sv/fds_datapath.sv]
// Stack memory, operand registers, ALU and divider of the Forth stack unit.
module fds_datapath import fds_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int CELL_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_op                  i_op,
    input  logic [31:0]          i_literal,
    output t_sts                 o_sts,
    output logic [CELL_BITS-1:0] o_top,
    output logic [CELL_BITS-1:0] o_second,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_depth,
    output logic                 o_bzero
);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SW = $clog2(CELL_BITS);

    // Every cell lives in memory; the top two are also kept in registers.
    logic [CELL_BITS-1:0] r_mem [STACK_DEPTH];
    logic [CELL_BITS-1:0] r_top, r_sec, r_third, r_fourth;
    logic [DW-1:0]        r_depth;
    logic [CELL_BITS-1:0] w_a, w_b, w_res0, w_res1, w_res2, w_quot, w_rem;
    logic [CELL_BITS-1:0] w_lit, w_flagt;
    logic [DW-1:0]        w_base, w_newd;
    logic                 w_big;
    logic [CELL_BITS-1:0] w_fill;
    logic [2*CELL_BITS-1:0] w_prod;
    logic                 w_div_done;

    assign w_a = r_sec;
    assign w_b = r_top;
    assign o_bzero = (w_b == '0);
    assign o_top    = r_top;
    assign o_second = r_sec;
    assign o_depth  = r_depth;

    // The third and fourth cells are read from memory ahead of time.
    always_ff @(posedge i_clk) begin
        if (r_depth >= DW'(3)) begin
            r_third <= r_mem[AW'(r_depth - DW'(3))];
        end else begin
            r_third <= '0;
        end
        if (r_depth >= DW'(4)) begin
            r_fourth <= r_mem[AW'(r_depth - DW'(4))];
        end else begin
            r_fourth <= '0;
        end
    end

    fds_divider #(.CELL_BITS(CELL_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start), .i_step(i_cmd.div_step),
        .i_signed(i_op != OP_UMOD), .i_floor(i_op == OP_FMOD),
        .i_a(w_a), .i_b(w_b),
        .o_done(w_div_done), .o_quot(w_quot), .o_rem(w_rem)
    );
    assign o_sts.div_done = w_div_done;

    // Combinational ALU.
    assign w_lit  = CELL_BITS'(i_literal);
    assign w_flagt = '1;
    assign w_big  = (w_b >= CELL_BITS'(CELL_BITS));
    assign w_fill = w_a[CELL_BITS-1] ? '1 : '0;
    assign w_prod = w_a * w_b;
    always_comb begin
        w_res0 = '0;
        w_res1 = '0;
        w_res2 = '0;
        case (i_op)
            OP_LIT:   w_res0 = w_lit;
            OP_DUP:   begin w_res0 = w_b; w_res1 = w_b; end
            OP_SWAP:  begin w_res0 = w_b; w_res1 = w_a; end
            OP_NIP:   w_res0 = w_b;
            OP_OVER:  begin w_res0 = w_a; w_res1 = w_b; w_res2 = w_a; end
            OP_ADD:   w_res0 = w_a + w_b;
            OP_SUB:   w_res0 = w_a - w_b;
            OP_MUL:   w_res0 = w_prod[CELL_BITS-1:0];
            OP_DIV:   w_res0 = w_quot;
            OP_AND:   w_res0 = w_a & w_b;
            OP_OR:    w_res0 = w_a | w_b;
            OP_XOR:   w_res0 = w_a ^ w_b;
            OP_NEG:   w_res0 = ~w_b + 1'b1;
            OP_INV:   w_res0 = ~w_b;
            OP_2MUL:  w_res0 = {w_b[CELL_BITS-2:0], 1'b0};
            OP_2DIV:  w_res0 = {w_b[CELL_BITS-1], w_b[CELL_BITS-1:1]};
            OP_U2DIV: w_res0 = {1'b0, w_b[CELL_BITS-1:1]};
            OP_LSH:   w_res0 = w_big ? '0 : (w_a << w_b[SW-1:0]);
            OP_ASR:   w_res0 = w_big ? w_fill : CELL_BITS'($signed(w_a) >>> w_b[SW-1:0]);
            OP_LSR:   w_res0 = w_big ? '0 : (w_a >> w_b[SW-1:0]);
            OP_ULT:   w_res0 = (w_a < w_b) ? w_flagt : '0;
            OP_LT:    w_res0 = ($signed(w_a) < $signed(w_b)) ? w_flagt : '0;
            OP_GT:    w_res0 = ($signed(w_b) < $signed(w_a)) ? w_flagt : '0;
            OP_0LT:   w_res0 = w_b[CELL_BITS-1] ? w_flagt : '0;
            OP_0EQ:   w_res0 = (w_b == '0) ? w_flagt : '0;
            OP_UMOD, OP_FMOD: begin w_res0 = w_rem; w_res1 = w_quot; end
            default:  w_res0 = '0;
        endcase
    end

    assign w_base = r_depth - DW'(pop_count(i_op));
    assign w_newd = w_base + DW'(push_count(i_op));

    // Commit: rebuild top two registers and write new cells to memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_top   <= '0;
            r_sec   <= '0;
        end else if (i_cmd.commit) begin
            r_depth <= w_newd;
            case (push_count(i_op))
                2'd3: begin
                    // over: a b -- a b a, memory gains a at the old depth.
                    r_mem[AW'(r_depth)] <= w_res2;
                    r_top <= w_res2;
                    r_sec <= w_res1;
                end
                2'd2: begin
                    r_mem[AW'(w_base)] <= w_res0;
                    r_mem[AW'(w_base + DW'(1))] <= w_res1;
                    r_sec <= w_res0;
                    r_top <= w_res1;
                end
                2'd1: begin
                    r_mem[AW'(w_base)] <= w_res0;
                    r_top <= w_res0;
                    if (w_base == '0) begin
                        r_sec <= '0;
                    end else if (pop_count(i_op) == 2'd0) begin
                        r_sec <= r_top;
                    end else if (pop_count(i_op) == 2'd2) begin
                        r_sec <= r_third;
                    end
                end
                default: begin
                    if (pop_count(i_op) == 2'd1) begin
                        r_top <= (w_base >= DW'(1)) ? r_sec : '0;
                        r_sec <= (w_base >= DW'(2)) ? r_third : '0;
                    end else if (pop_count(i_op) == 2'd2) begin
                        r_top <= (w_base >= DW'(1)) ? r_third : '0;
                        r_sec <= (w_base >= DW'(2)) ? r_fourth : '0;
                    end
                end
            endcase
        end
    end
endmodule

[sv/fds_control.sv]
// Controller: checks, divider sequencing and the output register.
module fds_control import fds_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_op                  i_op,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] i_depth,
    input  logic                 i_bzero,
    input  t_sts                 i_sts,
    output t_cmd                 o_cmd,
    output logic [1:0]           o_err,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hold
);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SETTLE, S_OUT} t_state;
    t_state r_state;
    logic [1:0] r_err;
    logic       r_valid;
    logic [1:0] w_err;
    logic [DW:0] w_after;

    assign w_after = {1'b0, i_depth} - (DW+1)'(pop_count(i_op)) +
                     (DW+1)'(push_count(i_op));
    always_comb begin
        if (i_depth < DW'(pop_count(i_op))) w_err = ERR_UNFL;
        else if (w_after > (DW+1)'(STACK_DEPTH)) w_err = ERR_OVFL;
        else if (is_div(i_op) && i_bzero) w_err = ERR_DIVZ;
        else w_err = ERR_OK;
    end

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_hold  = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        if (r_state == S_IDLE && i_valid && o_ready && w_err == ERR_OK) begin
            if (is_div(i_op)) begin
                o_cmd.div_start = 1'b1;
            end else begin
                o_cmd.commit = 1'b1;
            end
        end
        if (r_state == S_DIV) o_cmd.div_step = 1'b1;
        if (r_state == S_SETTLE) begin
            o_cmd.commit = 1'b1;
        end
    end

    // State and the result-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_err   <= ERR_OK;
        end else begin
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_err <= w_err;
                        if (w_err == ERR_OK && is_div(i_op)) r_state <= S_DIV;
                        else r_valid <= 1'b1;
                    end
                end
                S_DIV:    if (i_sts.div_done) r_state <= S_SETTLE;
                S_SETTLE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end
    assign o_err = r_err;
    assign o_out_valid = r_valid;
endmodule

[sv/forth_data_stack_alu_checker.sv]
// Port checker for the Forth stack unit, bound to the top level.
`include "forth_data_stack_alu_macros.svh"
module forth_data_stack_alu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    `FDS_ASSERT_IMP(a_depth_max, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[69:64] <= 6'd32, "depth beyond stack size")
    `FDS_ASSERT_IMP(a_no_take_while_full, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "word taken while result pending")
    `FDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `FDS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[69:64] == 6'd0, m_axis_tdata[63:0] == 64'd0, "empty stack shows data")
endmodule

bind forth_data_stack_alu forth_data_stack_alu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

[test/tb_forth_data_stack_alu.sv]
// Testbench for the Forth data-stack unit: random and directed words checked against a predictor.
`timescale 1ns / 1ps

// Scoreboard holding the predicted stack and the queue of expected results.
class fds_stack_scoreboard;
    bit [31:0] cells [32];
    int unsigned depth;
    bit [71:0] expected_q [$];
    int errors;

    function new();
        depth = 0;
        errors = 0;
    endfunction

    // Work out the result of one accepted word and queue it.
    function void note_word(bit [4:0] op, bit [31:0] lit);
        int unsigned pops, pushes, i;
        bit [31:0] a, b, q, r, ma, mb;
        bit [31:0] res [3];
        bit [1:0] err;
        pops = 2;
        pushes = 1;
        case (op)
            fds_pkg::OP_LIT, fds_pkg::OP_NOP29, fds_pkg::OP_NOP30, fds_pkg::OP_NOP31: pops = 0;
            fds_pkg::OP_DUP, fds_pkg::OP_DROP, fds_pkg::OP_NEG, fds_pkg::OP_INV,
            fds_pkg::OP_2MUL, fds_pkg::OP_2DIV, fds_pkg::OP_U2DIV, fds_pkg::OP_0LT,
            fds_pkg::OP_0EQ: pops = 1;
            default: pops = 2;
        endcase
        case (op)
            fds_pkg::OP_DROP, fds_pkg::OP_2DROP, fds_pkg::OP_NOP29, fds_pkg::OP_NOP30,
            fds_pkg::OP_NOP31: pushes = 0;
            fds_pkg::OP_DUP, fds_pkg::OP_SWAP, fds_pkg::OP_UMOD, fds_pkg::OP_FMOD: pushes = 2;
            fds_pkg::OP_OVER: pushes = 3;
            default: pushes = 1;
        endcase
        err = fds_pkg::ERR_OK;
        res[0] = 0; res[1] = 0; res[2] = 0;
        if (depth < pops) begin
            err = fds_pkg::ERR_UNFL;
        end else if (depth - pops + pushes > 32) begin
            err = fds_pkg::ERR_OVFL;
        end else begin
            b = (pops >= 1) ? cells[depth - 1] : 0;
            a = (pops >= 2) ? cells[depth - 2] : 0;
            if ((op == fds_pkg::OP_DIV || op == fds_pkg::OP_UMOD || op == fds_pkg::OP_FMOD)
                    && b == 0) begin
                err = fds_pkg::ERR_DIVZ;
            end else begin
                // Truncated signed quotient and remainder, used by / and /mod.
                ma = a[31] ? -a : a;
                mb = (b != 0 && b[31]) ? -b : b;
                q = (mb != 0) ? ma / mb : 0;
                r = (mb != 0) ? ma % mb : 0;
                if (a[31] ^ b[31]) q = -q;
                if (a[31]) r = -r;
                case (op)
                    fds_pkg::OP_LIT:   res[0] = lit;
                    fds_pkg::OP_DUP:   begin res[0] = b; res[1] = b; end
                    fds_pkg::OP_SWAP:  begin res[0] = b; res[1] = a; end
                    fds_pkg::OP_NIP:   res[0] = b;
                    fds_pkg::OP_OVER:  begin res[0] = a; res[1] = b; res[2] = a; end
                    fds_pkg::OP_ADD:   res[0] = a + b;
                    fds_pkg::OP_SUB:   res[0] = a - b;
                    fds_pkg::OP_MUL:   res[0] = a * b;
                    fds_pkg::OP_DIV:   res[0] = q;
                    fds_pkg::OP_AND:   res[0] = a & b;
                    fds_pkg::OP_OR:    res[0] = a | b;
                    fds_pkg::OP_XOR:   res[0] = a ^ b;
                    fds_pkg::OP_NEG:   res[0] = -b;
                    fds_pkg::OP_INV:   res[0] = ~b;
                    fds_pkg::OP_2MUL:  res[0] = b << 1;
                    fds_pkg::OP_2DIV:  res[0] = $signed(b) >>> 1;
                    fds_pkg::OP_U2DIV: res[0] = b >> 1;
                    fds_pkg::OP_LSH:   res[0] = (b >= 32) ? 0 : a << b;
                    fds_pkg::OP_ASR:
                        res[0] = (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b);
                    fds_pkg::OP_LSR:   res[0] = (b >= 32) ? 0 : a >> b;
                    fds_pkg::OP_ULT:   res[0] = (a < b) ? '1 : 0;
                    fds_pkg::OP_LT:    res[0] = ($signed(a) < $signed(b)) ? '1 : 0;
                    fds_pkg::OP_GT:    res[0] = ($signed(b) < $signed(a)) ? '1 : 0;
                    fds_pkg::OP_0LT:   res[0] = b[31] ? '1 : 0;
                    fds_pkg::OP_0EQ:   res[0] = (b == 0) ? '1 : 0;
                    fds_pkg::OP_UMOD:  begin res[0] = a % b; res[1] = a / b; end
                    fds_pkg::OP_FMOD: begin
                        // Floor toward minus infinity when the signs differ.
                        if (r != 0 && (a[31] ^ b[31])) begin
                            q = q - 1;
                            r = r + b;
                        end
                        res[0] = r; res[1] = q;
                    end
                    default: ;
                endcase
            end
            if (err == fds_pkg::ERR_OK) begin
                for (i = 0; i < pushes; i++) cells[depth - pops + i] = res[i];
                depth = depth - pops + pushes;
            end
        end
        expected_q.push_back({err, depth[5:0],
                              (depth >= 2) ? cells[depth - 2] : 32'd0,
                              (depth >= 1) ? cells[depth - 1] : 32'd0});
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(bit [71:0] got);
        bit [71:0] exp_word;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_word = expected_q.pop_front();
        if (got[31:0] !== exp_word[31:0])
            $display("%0t: top expected %h actual %h", $time, exp_word[31:0], got[31:0]);
        if (got[63:32] !== exp_word[63:32])
            $display("%0t: second expected %h actual %h", $time, exp_word[63:32], got[63:32]);
        if (got[69:64] !== exp_word[69:64])
            $display("%0t: depth expected %0d actual %0d", $time, exp_word[69:64], got[69:64]);
        if (got[71:70] !== exp_word[71:70])
            $display("%0t: error expected %0d actual %0d", $time, exp_word[71:70], got[71:70]);
        if (got !== exp_word) errors++;
    endfunction
endclass

module tb_forth_data_stack_alu;
    import fds_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // mode[4:0], literal[36:5], zeros
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // top, second, depth, error

    fds_stack_scoreboard stack_sb;
    bit quiet_phase;
    longint cycle_count;

    forth_data_stack_alu i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: sample at the rising edge, stall in random bursts outside the quiet phase.
    initial begin
        int gap;
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 18);
                m_axis_tready <= 0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) stack_sb.check_result(m_axis_tdata);
        end
    end

    // Send one word and wait for its acceptance; random idle gap first.
    task automatic send_word(input t_op op, input bit [31:0] lit);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {3'b0, lit, op};
        do @(posedge i_clk); while (!s_axis_tready);
        stack_sb.note_word(op, lit);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 0;
        while (stack_sb.expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick a random literal biased toward edge values.
    function automatic bit [31:0] pick_literal();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 0;
            3: return $urandom_range(0, 40);
            4: return -$urandom_range(1, 8);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        t_op op;
        stack_sb = new();
        quiet_phase = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: underflow on empty, edge literals, division corners, big shifts.
        send_word(OP_DROP, 0);
        send_word(OP_LIT, 32'hFFFF_FFFF);
        send_word(OP_ADD, 0);
        send_word(OP_LIT, 32'h8000_0000);
        send_word(OP_LIT, 32'hFFFF_FFFF);
        send_word(OP_DIV, 0);
        send_word(OP_LIT, 32'h8000_0000);
        send_word(OP_LIT, 32'hFFFF_FFFF);
        send_word(OP_FMOD, 0);
        send_word(OP_LIT, 0);
        send_word(OP_UMOD, 0);
        send_word(OP_LIT, 33);
        send_word(OP_ASR, 0);
        send_word(OP_LIT, 32);
        send_word(OP_LSH, 0);
        send_word(OP_NOP31, 32'h5555_5555);
        send_word(OP_LIT, -7);
        send_word(OP_LIT, 2);
        send_word(OP_FMOD, 0);
        send_word(OP_2DROP, 0);
        send_word(OP_2DROP, 0);
        // Fill to overflow.
        for (int i = 0; i < 33; i++) send_word(OP_LIT, $urandom);
        send_word(OP_OVER, 0);
        for (int i = 0; i < 17; i++) send_word(OP_2DROP, 0);

        // Hold off until every result is back.
        drain_results();

        // Random: keep the stack mostly populated so the operators do real work.
        for (n = 0; n < 480; n++) begin
            if (n == 400) quiet_phase = 1;
            if (stack_sb.depth < 3 && $urandom_range(0, 3) != 0) op = OP_LIT;
            else if (stack_sb.depth > 28 && $urandom_range(0, 1) == 0) op = OP_2DROP;
            else op = t_op'($urandom_range(0, 31));
            send_word(op, pick_literal());
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (stack_sb.errors == 0 && stack_sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/fds_pkg.sv
sv/fds_divider.sv
sv/fds_datapath.sv
sv/fds_control.sv
sv/forth_data_stack_alu.sv
sv/forth_data_stack_alu_checker.sv
test/tb_forth_data_stack_alu.sv
